FILE: rtl/core/assert_macros.svh
// assertion macros used by the rmsd top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RMSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define RMSD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/core/rmsd_pkg.sv
// types and constants of the rmsd block
package rmsd_pkg;

  localparam int unsigned COORD_W  = 20;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned ROW_W    = 54;
  localparam int unsigned TRANS_W  = 60;
  localparam int unsigned CFG_W    = 60;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RMSD_W   = 24;
  localparam int unsigned TOTAL_W  = 17;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned MUL_W    = 26;
  localparam int unsigned PROD_W   = 52;
  localparam int unsigned ACC_W    = 41;
  localparam int unsigned DIST_W   = 54;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned MAX_PAIRS_DEF = 65536;

  localparam logic [ROW_W-1:0] ROT_X_RST = ROW_W'(65536);
  localparam logic [ROW_W-1:0] ROT_Y_RST = ROW_W'(65536) << 18;
  localparam logic [ROW_W-1:0] ROT_Z_RST = ROW_W'(65536) << 36;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_X = 2'd0,
    CFG_ROT_Y = 2'd1,
    CFG_ROT_Z = 2'd2,
    CFG_TRANS = 2'd3
  } cfg_reg_e;

  // main sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_ROOT,
    ST_FIN
  } state_e;

  // divide and root unit phases
  typedef enum logic [2:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT,
    DS_RND,
    DS_DONE
  } ds_phase_e;

  // tag carried along with each product
  typedef struct packed {
    logic       sq;
    logic [1:0] axis;
    logic [1:0] col;
  } mul_tag_t;

endpackage

FILE: rtl/core/rmsd_mul.sv
// shared signed multiplier with registered product and tag
module rmsd_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [rmsd_pkg::MUL_W-1:0]   a_i,
  input  logic signed [rmsd_pkg::MUL_W-1:0]   b_i,
  input  rmsd_pkg::mul_tag_t                  tag_i,
  output logic                                valid_o,
  output logic signed [rmsd_pkg::PROD_W-1:0]  p_o,
  output rmsd_pkg::mul_tag_t                  tag_o
);

  logic                               valid_q;
  logic signed [rmsd_pkg::PROD_W-1:0] p_q;
  rmsd_pkg::mul_tag_t                 tag_q;

  // product valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // product and tag
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p_q   <= a_i * b_i;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign p_o     = p_q;
  assign tag_o   = tag_q;

endmodule

FILE: rtl/core/rmsd_divsqrt.sv
// bit-serial mean divide followed by digit-serial square root with rounding
module rmsd_divsqrt #(
  parameter int unsigned CNT_W = 17
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rmsd_pkg::SUM_W-1:0]          num_i,
  input  logic [CNT_W-1:0]                    den_i,
  input  logic                                ack_i,
  output logic                                done_o,
  output logic [rmsd_pkg::RMSD_W-1:0]         value_o,
  output logic                                sat_o
);

  localparam int unsigned STEP_W = 6;
  localparam int unsigned SREM_W = rmsd_pkg::ROOT_W + 2;

  rmsd_pkg::ds_phase_e phase_q, phase_d;
  logic [STEP_W-1:0]              step_q;
  logic [rmsd_pkg::SUM_W-1:0]     quo_q;
  logic [CNT_W:0]                 rem_q;
  logic [CNT_W-1:0]               den_q;
  logic [rmsd_pkg::ROOT_W-1:0]    root_q;
  logic [SREM_W-1:0]              srem_q;
  logic [rmsd_pkg::RMSD_W-1:0]    value_q;
  logic                           sat_q;

  logic [CNT_W+1:0]  div_sh;
  logic [CNT_W+1:0]  div_try;
  logic              div_ok;
  logic [SREM_W:0]   sq_sh;
  logic [SREM_W:0]   sq_try;
  logic              sq_ok;
  logic [rmsd_pkg::ROOT_W:0] rnd;

  // divide step: shift in next dividend bit, compare with divisor
  assign div_sh  = {rem_q, quo_q[rmsd_pkg::SUM_W-1]};
  assign div_try = div_sh - (CNT_W+2)'(den_q);
  assign div_ok  = !div_try[CNT_W+1];

  // root step: bring in two bits, try 4r+1
  assign sq_sh  = {srem_q[SREM_W-2:0], quo_q[rmsd_pkg::SUM_W-1 -: 2]};
  assign sq_try = sq_sh - (SREM_W+1)'({root_q, 2'b01});
  assign sq_ok  = !sq_try[SREM_W];

  // round to nearest from the remainder
  assign rnd = (rmsd_pkg::ROOT_W+1)'(root_q) +
               (rmsd_pkg::ROOT_W+1)'(srem_q > SREM_W'(root_q));

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      rmsd_pkg::DS_IDLE: if (start_i) phase_d = rmsd_pkg::DS_DIV;
      rmsd_pkg::DS_DIV:  if (step_q == STEP_W'(rmsd_pkg::SUM_W - 1)) phase_d = rmsd_pkg::DS_SQRT;
      rmsd_pkg::DS_SQRT: if (step_q == STEP_W'(rmsd_pkg::ROOT_W - 1)) phase_d = rmsd_pkg::DS_RND;
      rmsd_pkg::DS_RND:  phase_d = rmsd_pkg::DS_DONE;
      rmsd_pkg::DS_DONE: if (ack_i) phase_d = rmsd_pkg::DS_IDLE;
      default:           phase_d = rmsd_pkg::DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rmsd_pkg::DS_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      if (phase_q != phase_d) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      rmsd_pkg::DS_IDLE: begin
        quo_q <= num_i;
        den_q <= den_i;
        rem_q <= '0;
      end
      rmsd_pkg::DS_DIV: begin
        quo_q  <= {quo_q[rmsd_pkg::SUM_W-2:0], div_ok};
        rem_q  <= div_ok ? div_try[CNT_W:0] : div_sh[CNT_W:0];
        root_q <= '0;
        srem_q <= '0;
      end
      rmsd_pkg::DS_SQRT: begin
        quo_q  <= {quo_q[rmsd_pkg::SUM_W-3:0], 2'b00};
        srem_q <= sq_ok ? sq_try[SREM_W-1:0] : sq_sh[SREM_W-1:0];
        root_q <= {root_q[rmsd_pkg::ROOT_W-2:0], sq_ok};
      end
      rmsd_pkg::DS_RND: begin
        sat_q   <= rnd[rmsd_pkg::ROOT_W:rmsd_pkg::RMSD_W] != '0;
        value_q <= (rnd[rmsd_pkg::ROOT_W:rmsd_pkg::RMSD_W] != '0) ? '1
                   : rnd[rmsd_pkg::RMSD_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign done_o  = phase_q == rmsd_pkg::DS_DONE;
  assign value_o = value_q;
  assign sat_o   = sat_q;

endmodule

FILE: rtl/core/rmsd_after_superposition.sv
// rmsd top level: transform, squared distance accumulation and final root
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, ref_*, mov_*, last | to block
//  out     | out_valid_o/out_ready_i, rmsd, total, sat | from block
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | to block, no stall
//
// each pair runs twelve products through the single shared multiplier
// (nine rotation terms, three squares), then the pipeline drains and the accumulator updates.
// the last pair of a set is followed by the start, 64 divide steps, 32 root steps,
// a rounding step and the result load.
// reset clears accumulator, count and flags and loads the identity rotation.
// a held result in the output register only stalls the next set's final load.
`include "assert_macros.svh"

module rmsd_after_superposition #(
  parameter int unsigned MAX_PAIRS = rmsd_pkg::MAX_PAIRS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rmsd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rmsd_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rmsd_pkg::COORD_W-1:0]  ref_x_i,
  input  logic signed [rmsd_pkg::COORD_W-1:0]  ref_y_i,
  input  logic signed [rmsd_pkg::COORD_W-1:0]  ref_z_i,
  input  logic signed [rmsd_pkg::COORD_W-1:0]  mov_x_i,
  input  logic signed [rmsd_pkg::COORD_W-1:0]  mov_y_i,
  input  logic signed [rmsd_pkg::COORD_W-1:0]  mov_z_i,
  input  logic                                 is_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rmsd_pkg::RMSD_W-1:0]          rmsd_value_o,
  output logic [rmsd_pkg::TOTAL_W-1:0]         pair_total_o,
  output logic                                 saturated_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int unsigned D_W   = rmsd_pkg::MUL_W;
  localparam int unsigned T_W   = rmsd_pkg::ACC_W - 16;

  rmsd_pkg::state_e state_q, state_d;

  // configuration
  logic [rmsd_pkg::ROW_W-1:0]   rot_q [3];
  logic [rmsd_pkg::TRANS_W-1:0] trans_q;

  // captured pair
  logic signed [rmsd_pkg::COORD_W-1:0] ref_q [3];
  logic signed [rmsd_pkg::COORD_W-1:0] mov_q [3];
  logic                                last_q;

  // issue counters
  logic [1:0] axis_q, col_q;
  logic       issue;
  logic       issue_end;

  // pipeline values
  logic signed [rmsd_pkg::ACC_W-1:0] acc_q, tsum_q;
  logic                              tv_q;
  logic [1:0]                        taxis_q;
  logic signed [D_W-1:0]             d_q [3];
  logic [rmsd_pkg::DIST_W-1:0]       dist_q;
  logic                              upd_q;

  // accumulator state
  logic [rmsd_pkg::SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       sat_q;

  // output register
  logic                        out_v_q;
  logic [rmsd_pkg::RMSD_W-1:0] out_rmsd_q;
  logic [rmsd_pkg::TOTAL_W-1:0] out_total_q;
  logic                        out_sat_q;

  // multiplier and root unit
  logic signed [D_W-1:0]              mul_a, mul_b;
  rmsd_pkg::mul_tag_t                 mul_tag;
  logic                               prod_v;
  logic signed [rmsd_pkg::PROD_W-1:0] prod;
  rmsd_pkg::mul_tag_t                 prod_tag;
  logic                               ds_start, ds_done, ds_ack, ds_sat;
  logic [rmsd_pkg::RMSD_W-1:0]        ds_value;

  logic [rmsd_pkg::ROW_W-1:0]         row_sel;
  logic signed [rmsd_pkg::COEF_W-1:0] coef_sel;
  logic signed [rmsd_pkg::COORD_W-1:0] trans_sel;
  logic signed [rmsd_pkg::ACC_W-1:0]  trans_ext;
  logic                               in_xfer, out_free, fin_load;
  logic [rmsd_pkg::SUM_W:0]           sum_add;
  logic [CNT_W+rmsd_pkg::TOTAL_W-1:0] cnt_ext;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_v_q || out_ready_i;
  assign issue_end = (axis_q == 2'd3) && (col_q == 2'd2);

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    issue      = 1'b0;
    ds_start   = 1'b0;
    ds_ack     = 1'b0;
    fin_load   = 1'b0;
    unique case (state_q)
      rmsd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = rmsd_pkg::ST_RUN;
      end
      rmsd_pkg::ST_RUN: begin
        issue = 1'b1;
        if (issue_end) state_d = rmsd_pkg::ST_WAIT;
      end
      rmsd_pkg::ST_WAIT: begin
        if (upd_q) state_d = last_q ? rmsd_pkg::ST_ROOT : rmsd_pkg::ST_IDLE;
      end
      rmsd_pkg::ST_ROOT: begin
        ds_start = 1'b1;
        state_d  = rmsd_pkg::ST_FIN;
      end
      rmsd_pkg::ST_FIN: begin
        if (ds_done && out_free) begin
          ds_ack   = 1'b1;
          fin_load = 1'b1;
          state_d  = rmsd_pkg::ST_IDLE;
        end
      end
      default: state_d = rmsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= rmsd_pkg::ROT_X_RST;
      rot_q[1] <= rmsd_pkg::ROT_Y_RST;
      rot_q[2] <= rmsd_pkg::ROT_Z_RST;
      trans_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (rmsd_pkg::cfg_reg_e'(cfg_idx_i))
        rmsd_pkg::CFG_ROT_X: rot_q[0] <= cfg_data_i[rmsd_pkg::ROW_W-1:0];
        rmsd_pkg::CFG_ROT_Y: rot_q[1] <= cfg_data_i[rmsd_pkg::ROW_W-1:0];
        rmsd_pkg::CFG_ROT_Z: rot_q[2] <= cfg_data_i[rmsd_pkg::ROW_W-1:0];
        rmsd_pkg::CFG_TRANS: trans_q  <= cfg_data_i[rmsd_pkg::TRANS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // capture the pair on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ref_q[0] <= ref_x_i;
      ref_q[1] <= ref_y_i;
      ref_q[2] <= ref_z_i;
      mov_q[0] <= mov_x_i;
      mov_q[1] <= mov_y_i;
      mov_q[2] <= mov_z_i;
      last_q   <= is_last_i;
    end
  end

  // issue counters: col runs 0..2, axis 0..2 for rotation, 3 for squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= '0;
      col_q  <= '0;
    end else if (in_xfer) begin
      axis_q <= '0;
      col_q  <= '0;
    end else if (issue) begin
      col_q  <= (col_q == 2'd2) ? 2'd0 : col_q + 2'd1;
      if (col_q == 2'd2) axis_q <= axis_q + 2'd1;
    end
  end

  // operand selection
  always_comb begin
    unique case (axis_q)
      2'd0:    row_sel = rot_q[0];
      2'd1:    row_sel = rot_q[1];
      default: row_sel = rot_q[2];
    endcase
    unique case (col_q)
      2'd0:    coef_sel = row_sel[rmsd_pkg::COEF_W-1:0];
      2'd1:    coef_sel = row_sel[2*rmsd_pkg::COEF_W-1:rmsd_pkg::COEF_W];
      default: coef_sel = row_sel[3*rmsd_pkg::COEF_W-1:2*rmsd_pkg::COEF_W];
    endcase
    if (axis_q == 2'd3) begin
      mul_a = d_q[col_q];
      mul_b = d_q[col_q];
    end else begin
      mul_a = D_W'(coef_sel);
      mul_b = D_W'(mov_q[col_q]);
    end
    mul_tag.sq   = axis_q == 2'd3;
    mul_tag.axis = axis_q;
    mul_tag.col  = col_q;
  end

  rmsd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (issue),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .tag_i   (mul_tag),
    .valid_o (prod_v),
    .p_o     (prod),
    .tag_o   (prod_tag)
  );

  // translation term of the axis now arriving, in Q.24
  always_comb begin
    unique case (prod_tag.axis)
      2'd0:    trans_sel = trans_q[rmsd_pkg::COORD_W-1:0];
      2'd1:    trans_sel = trans_q[2*rmsd_pkg::COORD_W-1:rmsd_pkg::COORD_W];
      default: trans_sel = trans_q[3*rmsd_pkg::COORD_W-1:2*rmsd_pkg::COORD_W];
    endcase
    trans_ext = rmsd_pkg::ACC_W'(trans_sel) <<< 16;
  end

  // product accumulation, rounding and distance squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q  <= 1'b0;
      upd_q <= 1'b0;
    end else begin
      tv_q  <= prod_v && !prod_tag.sq && (prod_tag.col == 2'd2);
      upd_q <= prod_v && prod_tag.sq && (prod_tag.col == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_v && !prod_tag.sq) begin
      unique case (prod_tag.col)
        2'd0:    acc_q  <= rmsd_pkg::ACC_W'(prod) + trans_ext;
        2'd1:    acc_q  <= acc_q + rmsd_pkg::ACC_W'(prod);
        default: begin
          tsum_q  <= acc_q + rmsd_pkg::ACC_W'(prod) + rmsd_pkg::ACC_W'(32768);
          taxis_q <= prod_tag.axis;
        end
      endcase
    end
    if (prod_v && prod_tag.sq) begin
      if (prod_tag.col == 2'd0) begin
        dist_q <= rmsd_pkg::DIST_W'(prod[rmsd_pkg::PROD_W-1:0]);
      end else begin
        dist_q <= dist_q + rmsd_pkg::DIST_W'(prod[rmsd_pkg::PROD_W-1:0]);
      end
    end
    // floor of the rounded Q.24 sum gives the Q.8 coordinate
    if (tv_q) begin
      d_q[taxis_q] <= D_W'(ref_q[taxis_q]) -
                      D_W'($signed(tsum_q[rmsd_pkg::ACC_W-1 -: T_W]));
    end
  end

  // saturating accumulator and pair count
  assign sum_add = {1'b0, sum_q} + (rmsd_pkg::SUM_W+1)'(dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
    end else if (fin_load) begin
      sum_q <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
    end else if (upd_q) begin
      if (cnt_q >= CNT_W'(MAX_PAIRS)) begin
        sat_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (sum_add[rmsd_pkg::SUM_W]) begin
          sum_q <= '1;
          sat_q <= 1'b1;
        end else begin
          sum_q <= sum_add[rmsd_pkg::SUM_W-1:0];
        end
      end
    end
  end

  rmsd_divsqrt #(
    .CNT_W (CNT_W)
  ) u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .num_i   (sum_q),
    .den_i   (cnt_q),
    .ack_i   (ds_ack),
    .done_o  (ds_done),
    .value_o (ds_value),
    .sat_o   (ds_sat)
  );

  // output register
  assign cnt_ext = {{rmsd_pkg::TOTAL_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_rmsd_q  <= ds_value;
      out_total_q <= cnt_ext[rmsd_pkg::TOTAL_W-1:0];
      out_sat_q   <= sat_q || ds_sat;
    end
  end

  assign out_valid_o  = out_v_q;
  assign rmsd_value_o = out_rmsd_q;
  assign pair_total_o = out_total_q;
  assign saturated_o  = out_sat_q;

  // checks
  `RMSD_ASSERT(a_busy_after_xfer, in_xfer |=> !in_ready_o)
  `RMSD_NEVER(a_cnt_range, cnt_q > CNT_W'(MAX_PAIRS))
  `RMSD_NEVER(a_no_prod_idle, prod_v && (state_q == rmsd_pkg::ST_IDLE))
  `RMSD_ASSERT(a_load_needs_room, fin_load |-> (!out_v_q || out_ready_i))

endmodule
